FILE: design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CH_W  = 8;   // channel width
  localparam int HUE_W = 15;  // hue width, 1/64 degree units
  localparam int QW    = 12;  // quotient bits produced by the divider chain

  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

  // pipeline length: front stage, one stage per quotient bit, output stage
  localparam int NSTAGE = QW + 2;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sect_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value;
  } hsv_out_t;

  // in-flight state of one pixel; the *_acc fields hold the remaining
  // dividend bits at the top and the quotient bits shifted in at the bottom
  typedef struct packed {
    logic [CH_W-1:0] h_rem;
    logic [QW-1:0]   h_acc;
    logic [CH_W-1:0] s_rem;
    logic [QW-1:0]   s_acc;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] value;
    logic            neg;
    logic            grey;
    sect_t           sect;
  } pipe_t;

endpackage

FILE: design/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step
// One restoring division step for both the hue and the saturation quotient.
// ----------------------------------------------------------------------------
module rhc_div_step
  import rhc_pkg::*;
(
  input  pipe_t cur,
  output pipe_t nxt
);

  logic [CH_W:0] h_ext;
  logic [CH_W:0] s_ext;
  logic          h_ge;
  logic          s_ge;

  always_comb begin
    nxt   = cur;
    // hue: divide by delta
    h_ext = {cur.h_rem, cur.h_acc[QW-1]};
    h_ge  = (h_ext >= {1'b0, cur.delta});
    nxt.h_rem = h_ge ? CH_W'(h_ext - {1'b0, cur.delta}) : h_ext[CH_W-1:0];
    nxt.h_acc = {cur.h_acc[QW-2:0], h_ge};
    // saturation: divide by max
    s_ext = {cur.s_rem, cur.s_acc[QW-1]};
    s_ge  = (s_ext >= {1'b0, cur.value});
    nxt.s_rem = s_ge ? CH_W'(s_ext - {1'b0, cur.value}) : s_ext[CH_W-1:0];
    nxt.s_acc = {cur.s_acc[QW-2:0], s_ge};
  end

endmodule

FILE: design/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV conversion, one pixel per clock while out_stall is low.
// ----------------------------------------------------------------------------
//
//  channel | ports                               | payload
//  --------+-------------------------------------+-----------------------------
//  in      | in_valid, in_stall (out), in_data   | red, green, blue (8b each)
//  out     | out_valid, out_stall (in), out_data | hue (15b), saturation, value
//
//  One pixel per clock sustained while out_stall is low; 14 register stages: a front stage
//  (max/min/sector), 12 restoring divider steps (one quotient bit each),
//  and the output stage that applies the sector base and hue wrap.
//  Reset (rst_n low, synchronous) clears all stage valid bits only.
//  The load-enable chain carries a stall back to the input in the same cycle;
//  empty stages still fill, so bubbles collapse and in_stall rises only when
//  every stage holds a request and out_stall is high.
//
module rgb_to_hsv_converter
  import rhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pix_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hsv_out_t out_data
);

  // valid bits: [0] front, [1..QW] divider steps, [NSTAGE-1] output
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] rdy;

  pipe_t    pipe_r   [0:QW];
  pipe_t    step_nxt [1:QW];
  pipe_t    front_nxt;
  hsv_out_t out_r;
  hsv_out_t out_nxt;

  // --------------------------------------------------------------------------
  // Stage load enables: a stage may load when it is empty or its contents
  // move on in the same cycle.
  // --------------------------------------------------------------------------
  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // --------------------------------------------------------------------------
  // Front stage: max, min, sector and the two dividends.
  //   hue dividend = 3840 * |diff| = (15 * |diff|) << 8
  //   sat dividend = (255 * delta) << 4; four extra quotient bits are
  //   dropped at the output, which leaves floor(255*delta/max).
  // --------------------------------------------------------------------------
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] dlt;
  logic [CH_W-1:0] op_a;
  logic [CH_W-1:0] op_b;
  logic [CH_W-1:0] mag;
  logic [QW-1:0]   mag15;
  logic [2*CH_W-1:0] s16;
  sect_t           sect;

  always_comb begin
    mx  = (in_data.red > in_data.green) ? in_data.red : in_data.green;
    mx  = (mx > in_data.blue) ? mx : in_data.blue;
    mn  = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    mn  = (mn < in_data.blue) ? mn : in_data.blue;
    dlt = mx - mn;

    // ties go to red, then green
    if (in_data.red >= mx) begin
      sect = SECT_RED;
      op_a = in_data.green;
      op_b = in_data.blue;
    end else if (in_data.green >= mx) begin
      sect = SECT_GREEN;
      op_a = in_data.blue;
      op_b = in_data.red;
    end else begin
      sect = SECT_BLUE;
      op_a = in_data.red;
      op_b = in_data.green;
    end

    mag   = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    mag15 = QW'({mag, 4'b0000}) - QW'(mag);
    s16   = {dlt, 8'h00} - (2*CH_W)'(dlt);

    front_nxt.h_rem = mag15[QW-1:4];
    front_nxt.h_acc = {mag15[3:0], 8'h00};
    front_nxt.s_rem = s16[2*CH_W-1:CH_W];
    front_nxt.s_acc = {s16[CH_W-1:0], 4'b0000};
    front_nxt.delta = dlt;
    front_nxt.value = mx;
    front_nxt.neg   = (op_a < op_b);
    front_nxt.grey  = (dlt == '0);
    front_nxt.sect  = sect;
  end

  // --------------------------------------------------------------------------
  // Divider chain: one quotient bit per stage.
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= QW; k++) begin : g_step
    rhc_div_step u_step (
      .cur (pipe_r[k-1]),
      .nxt (step_nxt[k])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: sector base plus signed offset, wrapped into one turn.
  // Grey pixels force hue and saturation to zero.
  // --------------------------------------------------------------------------
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] q;

  always_comb begin
    case (pipe_r[QW].sect)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HUE_GREEN;
      SECT_BLUE:  base = HUE_BLUE;
      default:    base = '0;
    endcase
    q = HUE_W'(pipe_r[QW].h_acc);

    if (!pipe_r[QW].neg) begin
      out_nxt.hue = base + q;
    end else if (q > base) begin
      out_nxt.hue = HUE_W'({1'b0, base} + {1'b0, HUE_FULL} - {1'b0, q});
    end else begin
      out_nxt.hue = base - q;
    end
    out_nxt.saturation = pipe_r[QW].s_acc[QW-1:4];
    out_nxt.value      = pipe_r[QW].value;

    if (pipe_r[QW].grey) begin
      out_nxt.hue        = '0;
      out_nxt.saturation = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pipe_r[0] <= front_nxt;
    end
    for (int k = 1; k <= QW; k++) begin
      if (rdy[k]) begin
        pipe_r[k] <= step_nxt[k];
      end
    end
    if (rdy[NSTAGE-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[NSTAGE-1];
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // hue always lands inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hue < HUE_FULL))
    else $error("hue out of range");

  // black carries no hue or saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.value == '0) |->
      (out_data.hue == '0 && out_data.saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  // input is held off only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
